// File: hdl/rple_pkg.sv
// Package for the rainbow pattern LED bit encoder: mode and register codes,
// reset values, color wheel constants and the pixel descriptor type.
// Depends on nothing; the top level and rple_wheel use it by scoped names.
package rple_pkg;

	localparam int CODE_W  = 8;
	localparam int COLOR_W = 24;
	localparam int INDEX_W = 6;
	localparam int FRAME_W = 11;
	localparam int HUE_W   = 8;
	localparam int BITS_PER_PIXEL = 24;
	localparam int BIT_CNT_W = 5;

	// Pattern modes; the unused code behaves as solid color.
	localparam logic [1:0] MODE_SOLID   = 2'd0;
	localparam logic [1:0] MODE_RAINBOW = 2'd1;
	localparam logic [1:0] MODE_CYCLE   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_SOLID     = 2'd1;
	localparam logic [1:0] REG_ONE_CODE  = 2'd2;
	localparam logic [1:0] REG_ZERO_CODE = 2'd3;

	localparam logic [1:0]         RST_MODE      = MODE_RAINBOW;
	localparam logic [COLOR_W-1:0] RST_SOLID     = 24'd0;
	localparam logic [CODE_W-1:0]  RST_ONE_CODE  = 8'd248;
	localparam logic [CODE_W-1:0]  RST_ZERO_CODE = 8'd192;

	// Last frame counter values of the two animated patterns.
	localparam logic [FRAME_W-1:0] RAINBOW_LAST_FRAME = 11'd255;
	localparam logic [FRAME_W-1:0] CYCLE_LAST_FRAME   = 11'd1279;

	// Color wheel segment bounds.
	localparam logic [HUE_W-1:0] WHEEL_MAX  = 8'd255;
	localparam logic [HUE_W-1:0] WHEEL_SEG1 = 8'd85;
	localparam logic [HUE_W-1:0] WHEEL_SEG2 = 8'd170;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT = 5'd23;

	// One pixel waiting to be serialized.
	typedef struct packed {
		logic [HUE_W-1:0]   wheel_pos;
		logic               solid;
		logic [INDEX_W-1:0] pixel_index;
		logic               last_pixel;
		logic               last_frame;
	} pixel_item_t;

endpackage

// File: hdl/rple_req_if.sv
// Request channel of the rainbow pattern LED bit encoder: one word per pixel.
// Depends on nothing.
interface rple_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

// File: hdl/rple_code_if.sv
// Code byte channel of the rainbow pattern LED bit encoder: one word per color bit.
// Depends on nothing.
interface rple_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic [5:0] pixel_index;
	logic       pixel_done;
	logic       frame_done;
	logic       pattern_done;

	modport source(output valid, output code_byte, output pixel_index,
		output pixel_done, output frame_done, output pattern_done, input ready);
	modport sink(input valid, input code_byte, input pixel_index,
		input pixel_done, input frame_done, input pattern_done, output ready);
endinterface

// File: hdl/rainbow_pattern_led_bit_encoder.sv
// Rainbow pattern LED bit encoder, top level.
// Depends on rple_pkg, rple_req_if, rple_code_if and rple_wheel.
//
// Usage: every word on the req channel asks for the next pixel of the pattern
// that pattern_mode selects (solid color, rainbow, or evenly spread rainbow
// cycle). If restart is set, the pixel and frame counters are cleared before
// that pixel is produced. Each pixel's 24-bit GRB color leaves on the code
// channel MSB first as 24 words, one SPI code byte per color bit, marked with
// pixel_done, frame_done and pattern_done on the pixel's last word.
// The first code byte of a pixel comes from the serializer register, which is
// loaded from the one-pixel buffer that holds the accepted request. The code
// channel moves one byte per cycle while the receiver accepts; one request is
// buffered while the previous pixel is still being shifted out, so the output
// runs without gaps as long as requests keep up.
// When the receiver stalls, the current byte holds and the buffered request
// waits; req.ready drops once the buffer is full.
// Reset clears both counters, empties the buffer and the serializer, and loads
// the registers with their defaults (rainbow, black, 248 and 192).
// Configuration writes are meant for an idle block; the mode takes effect with the
// next request, the solid color on the next serializer load, the code bytes at once.
module rainbow_pattern_led_bit_encoder #(
	parameter int PIXELS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_idx,
	input  logic [23:0] cfg_data,
	rple_req_if.sink    req,
	rple_code_if.source code
);

	// Pixel counter width; it must hold PIXELS-1.
	localparam int PW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	// Per-pixel step of pixel*256/PIXELS, kept as quotient and remainder.
	localparam int QSTEP = 256 / PIXELS;
	localparam int RSTEP = 256 % PIXELS;

	// Configuration registers.
	logic [1:0]                     mode_q;
	logic [rple_pkg::COLOR_W-1:0]   solid_q;
	logic [rple_pkg::CODE_W-1:0]    one_code_q;
	logic [rple_pkg::CODE_W-1:0]    zero_code_q;

	// Pattern position: pixel, frame and the running pixel*256/PIXELS.
	logic [PW-1:0]                  pix_q;
	logic [rple_pkg::FRAME_W-1:0]   frame_q;
	logic [rple_pkg::HUE_W-1:0]     hue_q;
	logic [PW-1:0]                  hue_rem_q;

	// Buffered pixel, then the serializer.
	logic                           item_valid_s1;
	rple_pkg::pixel_item_t          item_s1;
	logic                           ser_valid_q;
	logic [rple_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic [rple_pkg::COLOR_W-1:0]   color_q;
	logic [rple_pkg::INDEX_W-1:0]   ser_index_q;
	logic                           ser_last_pixel_q;
	logic                           ser_last_frame_q;

	logic                           in_fire;
	logic                           out_fire;
	logic                           ser_last;
	logic                           ser_load;

	logic [PW-1:0]                  pix_cur;
	logic [rple_pkg::FRAME_W-1:0]   frame_cur;
	logic [rple_pkg::HUE_W-1:0]     hue_cur;
	logic [PW-1:0]                  hue_rem_cur;
	logic [PW:0]                    hue_rem_sum;
	logic                           hue_carry;
	logic [PW-1:0]                  hue_rem_next;
	logic [rple_pkg::HUE_W-1:0]     hue_next;
	rple_pkg::pixel_item_t          item_next;
	logic [rple_pkg::COLOR_W-1:0]   wheel_color;
	logic [rple_pkg::COLOR_W-1:0]   load_color;

	assign out_fire = ser_valid_q & code.ready;
	assign ser_last = (bit_cnt_q == rple_pkg::LAST_BIT);
	assign ser_load = item_valid_s1 & (~ser_valid_q | (out_fire & ser_last));
	assign req.ready = ~item_valid_s1 | ser_load;
	assign in_fire = req.valid & req.ready;

	// Position of the requested pixel and the marks it carries.
	always_comb begin
		pix_cur     = req.restart ? '0 : pix_q;
		frame_cur   = req.restart ? '0 : frame_q;
		hue_cur     = req.restart ? '0 : hue_q;
		hue_rem_cur = req.restart ? '0 : hue_rem_q;

		item_next.pixel_index = rple_pkg::INDEX_W'(pix_cur);
		item_next.last_pixel  = (pix_cur == PW'(PIXELS - 1));
		case (mode_q)
			rple_pkg::MODE_RAINBOW: begin
				item_next.solid      = 1'b0;
				item_next.wheel_pos  = rple_pkg::HUE_W'(pix_cur) + frame_cur[7:0];
				item_next.last_frame = (frame_cur >= rple_pkg::RAINBOW_LAST_FRAME);
			end
			rple_pkg::MODE_CYCLE: begin
				item_next.solid      = 1'b0;
				item_next.wheel_pos  = hue_cur + frame_cur[7:0];
				item_next.last_frame = (frame_cur >= rple_pkg::CYCLE_LAST_FRAME);
			end
			default: begin
				// Solid color is a one-frame pattern; the unused code joins it.
				item_next.solid      = 1'b1;
				item_next.wheel_pos  = '0;
				item_next.last_frame = 1'b1;
			end
		endcase

		// Advance pixel*256/PIXELS by one pixel with a single compare and subtract.
		hue_rem_sum = {1'b0, hue_rem_cur} + (PW + 1)'(RSTEP);
		hue_carry   = (hue_rem_sum >= (PW + 1)'(PIXELS));
		hue_rem_next = hue_carry ? PW'(hue_rem_sum - (PW + 1)'(PIXELS)) : PW'(hue_rem_sum);
		hue_next    = hue_cur + rple_pkg::HUE_W'(QSTEP) + rple_pkg::HUE_W'(hue_carry);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= rple_pkg::RST_MODE;
			solid_q     <= rple_pkg::RST_SOLID;
			one_code_q  <= rple_pkg::RST_ONE_CODE;
			zero_code_q <= rple_pkg::RST_ZERO_CODE;
		end else if (cfg_wen) begin
			case (cfg_idx)
				rple_pkg::REG_MODE:      mode_q      <= cfg_data[1:0];
				rple_pkg::REG_SOLID:     solid_q     <= cfg_data;
				rple_pkg::REG_ONE_CODE:  one_code_q  <= cfg_data[7:0];
				rple_pkg::REG_ZERO_CODE: zero_code_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Counters move on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q     <= '0;
			frame_q   <= '0;
			hue_q     <= '0;
			hue_rem_q <= '0;
		end else if (in_fire) begin
			if (item_next.last_pixel) begin
				pix_q     <= '0;
				hue_q     <= '0;
				hue_rem_q <= '0;
				frame_q   <= item_next.last_frame ? '0 : frame_cur + 1'b1;
			end else begin
				pix_q     <= pix_cur + 1'b1;
				hue_q     <= hue_next;
				hue_rem_q <= hue_rem_next;
				frame_q   <= frame_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			item_valid_s1 <= 1'b1;
		end else if (ser_load) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item_next;
		end
	end

	rple_wheel u_wheel (
		.wheel_pos (item_s1.wheel_pos),
		.color     (wheel_color)
	);

	assign load_color = item_s1.solid ? solid_q : wheel_color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
		end else if (ser_load) begin
			ser_valid_q <= 1'b1;
			bit_cnt_q   <= '0;
		end else if (out_fire) begin
			ser_valid_q <= ~ser_last;
			bit_cnt_q   <= bit_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			color_q          <= load_color;
			ser_index_q      <= item_s1.pixel_index;
			ser_last_pixel_q <= item_s1.last_pixel;
			ser_last_frame_q <= item_s1.last_frame;
		end else if (out_fire) begin
			color_q <= {color_q[rple_pkg::COLOR_W-2:0], 1'b0};
		end
	end

	assign code.valid        = ser_valid_q;
	assign code.code_byte    = color_q[rple_pkg::COLOR_W-1] ? one_code_q : zero_code_q;
	assign code.pixel_index  = ser_index_q;
	assign code.pixel_done   = ser_last;
	assign code.frame_done   = ser_last & ser_last_pixel_q;
	assign code.pattern_done = ser_last & ser_last_pixel_q & ser_last_frame_q;

endmodule

// File: hdl/rple_wheel.sv
// Color wheel: maps an 8-bit wheel position to a 24-bit GRB color.
// Depends on rple_pkg.
module rple_wheel (
	input  logic [rple_pkg::HUE_W-1:0]   wheel_pos,
	output logic [rple_pkg::COLOR_W-1:0] color
);

	logic [rple_pkg::HUE_W-1:0] q;
	logic [rple_pkg::HUE_W-1:0] q_seg;
	logic [rple_pkg::HUE_W-1:0] q3;
	logic [rple_pkg::HUE_W-1:0] red;
	logic [rple_pkg::HUE_W-1:0] green;
	logic [rple_pkg::HUE_W-1:0] blue;

	always_comb begin
		q = rple_pkg::WHEEL_MAX - wheel_pos;
		if (q < rple_pkg::WHEEL_SEG1) begin
			q_seg = q;
		end else if (q < rple_pkg::WHEEL_SEG2) begin
			q_seg = q - rple_pkg::WHEEL_SEG1;
		end else begin
			q_seg = q - rple_pkg::WHEEL_SEG2;
		end
		// The segment offset is at most 85, so three times it fits in a byte.
		q3 = {q_seg[6:0], 1'b0} + q_seg;
		if (q < rple_pkg::WHEEL_SEG1) begin
			red   = rple_pkg::WHEEL_MAX - q3;
			green = '0;
			blue  = q3;
		end else if (q < rple_pkg::WHEEL_SEG2) begin
			red   = '0;
			green = q3;
			blue  = rple_pkg::WHEEL_MAX - q3;
		end else begin
			red   = q3;
			green = rple_pkg::WHEEL_MAX - q3;
			blue  = '0;
		end
		color = {green, red, blue};
	end

endmodule
